>>> sv/sallcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sallcp_pkg
// shared constants and types of the suffix array and lcp builder
// ----------------------------------------------------------------------------
package sallcp_pkg;

   localparam int MAX_LEN_DEF  = 1024;
   localparam int ALPHABET_DEF = 256;

   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_READ = 2'd1;
   localparam logic [1:0] FUNC_LCP  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_NOT_BUILT = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] ch;
      logic       last;
      logic [9:0] index_a;
      logic [9:0] index_b;
   } cmd_type;

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] suffix_start;
      logic [9:0] suffix_rank;
      logic [9:0] lcp_value;
   } res_type;

endpackage

>>> sv/sallcp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sallcp_if
// request and response channel interfaces
// ----------------------------------------------------------------------------
interface sallcp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] ch;
   logic       last;
   logic [9:0] index_a;
   logic [9:0] index_b;

   modport source (output valid, func, ch, last, index_a, index_b, input ready);
   modport sink (input valid, func, ch, last, index_a, index_b, output ready);
endinterface

interface sallcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [9:0] suffix_start;
   logic [9:0] suffix_rank;
   logic [9:0] lcp_value;

   modport source (output valid, status, suffix_start, suffix_rank, lcp_value, input ready);
   modport sink (input valid, status, suffix_start, suffix_rank, lcp_value, output ready);
endinterface

>>> sv/sallcp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sallcp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sallcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/sallcp_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sallcp_seq
// sequencer and memories: load, prefix doubling sort, rank, kasai, queries
// ----------------------------------------------------------------------------
module sallcp_seq #(
   parameter int MAX_LEN  = 1024,
   parameter int ALPHABET = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  sallcp_pkg::cmd_type cmd,
   output logic               busy,
   output logic               done,
   output sallcp_pkg::res_type res
);
   import sallcp_pkg::*;

   localparam int AW      = $clog2(MAX_LEN);
   localparam int LW      = AW + 1;
   localparam int BUCKETS = MAX_LEN + ALPHABET + 1;
   localparam int BW      = $clog2(BUCKETS);
   localparam int KW      = BW;
   localparam int CW      = $clog2(BUCKETS + 1);
   localparam int XW      = (LW > 10) ? LW : 10;
   localparam int DW      = LW + 1;

   typedef enum logic [5:0] {
      S_IDLE, S_FIN, S_RD0, S_RD1, S_Q0, S_Q1, S_Q2, S_Q3,
      S_I0, S_I1, S_CLR, S_CN0, S_CN1, S_CN2, S_CN3, S_PR0, S_PR1,
      S_PL0, S_PL1, S_PL2, S_PL3, S_Y1, S_Y2A, S_Y2B,
      S_R0, S_R1, S_RA, S_RB, S_RC, S_RD, S_RE, S_RF, S_DEND,
      S_K0, S_K1, S_H0, S_H1, S_H2, S_H3, S_H4, S_H5
   } state_type;

   state_type      state_ff;
   logic [LW-1:0]  len_ff;
   logic           built_ff;
   logic           sel_ff;
   logic           csinit_ff;
   logic [CW-1:0]  i_ff;
   logic [CW-1:0]  m_ff;
   logic [LW-1:0]  p_ff;
   logic [LW-1:0]  acc_ff;
   logic [DW-1:0]  k_ff;
   logic [KW-1:0]  kv_ff;
   logic [AW-1:0]  s_ff;
   logic [AW-1:0]  a_ff;
   logic [AW-1:0]  b_ff;
   logic [KW-1:0]  ya_ff;
   logic [AW-1:0]  r_ff;
   logic [AW-1:0]  hi_ff;
   logic [AW-1:0]  ra_ff;
   logic [AW-1:0]  j_ff;
   logic [LW-1:0]  h_ff;
   logic [8:0]     ta_ff;
   logic [AW-1:0]  mn_ff;
   res_type        res_ff;

   // memory ports
   logic          txt_we;
   logic [AW-1:0] txt_wa, txt_ra;
   logic [7:0]    txt_wd, txt_rd;
   logic          sa_we;
   logic [AW-1:0] sa_wa, sa_ra, sa_wd, sa_rd;
   logic          rk_we;
   logic [AW-1:0] rk_wa, rk_ra, rk_wd, rk_rd;
   logic          lc_we;
   logic [AW-1:0] lc_wa, lc_ra, lc_wd, lc_rd;
   logic          cn_we;
   logic [BW-1:0] cn_wa, cn_ra;
   logic [LW-1:0] cn_wd, cn_rd;
   logic          x_we, y_we;
   logic [AW-1:0] x_wa, x_ra, y_wa, y_ra;
   logic [KW-1:0] x_wd, y_wd, x_rd, y_rd;
   logic          k0_we, k1_we;
   logic [AW-1:0] k0_wa, k0_ra, k1_wa, k1_ra;
   logic [KW-1:0] k0_wd, k1_wd, k0_rd, k1_rd;

   // combinational helpers
   logic [LW-1:0] n_w;
   logic [LW-1:0] len_eff;
   logic [7:0]    ch_sat;
   logic [XW-1:0] ia_x, ib_x, len_x;
   logic [DW-1:0] ak_w, bk_w, ih_w, jh_w;
   logic [8:0]    sym_b;
   logic [AW-1:0] hd_w;
   logic [AW-1:0] mn_new;
   logic [LW-1:0] cm1_w;
   res_type       res_start;

   assign n_w     = len_ff + LW'(1);
   assign len_eff = built_ff ? '0 : len_ff;
   assign ch_sat  = ({1'b0, cmd.ch} >= 9'(ALPHABET)) ? 8'(ALPHABET - 1) : cmd.ch;
   assign ia_x    = XW'(cmd.index_a);
   assign ib_x    = XW'(cmd.index_b);
   assign len_x   = XW'(len_ff);
   assign ak_w    = DW'(a_ff) + k_ff;
   assign bk_w    = DW'(b_ff) + k_ff;
   assign ih_w    = DW'(i_ff[LW-1:0]) + DW'(h_ff);
   assign jh_w    = DW'(j_ff) + DW'(h_ff);
   assign sym_b   = (jh_w < DW'(len_ff)) ? (9'(txt_rd) + 9'd1) : 9'd0;
   assign hd_w    = (h_ff != '0) ? AW'(h_ff - LW'(1)) : AW'(h_ff);
   assign mn_new  = (lc_rd < mn_ff) ? lc_rd : mn_ff;
   assign cm1_w   = cn_rd - LW'(1);

   // response fields known at accept time
   always_comb begin
      res_start = '0;
      case (cmd.func)
         FUNC_LOAD: begin
            if (len_eff >= LW'(MAX_LEN - 1)) begin
               res_start.status = ST_OVERFLOW;
            end
         end
         FUNC_READ: begin
            if (!built_ff) begin
               res_start.status = ST_NOT_BUILT;
            end else if (ia_x > len_x) begin
               res_start.status = ST_RANGE;
            end
         end
         FUNC_LCP: begin
            if (!built_ff) begin
               res_start.status = ST_NOT_BUILT;
            end else if (ia_x > len_x || ib_x > len_x) begin
               res_start.status = ST_RANGE;
            end else if (ia_x == ib_x) begin
               res_start.lcp_value = 10'(len_x - ia_x);
            end
         end
         default: begin
            res_start.status = ST_RANGE;
         end
      endcase
   end

   always_comb begin
      txt_we = 1'b0; txt_wa = '0; txt_wd = '0; txt_ra = '0;
      sa_we = 1'b0; sa_wa = '0; sa_wd = '0; sa_ra = '0;
      rk_we = 1'b0; rk_wa = '0; rk_wd = '0; rk_ra = '0;
      lc_we = 1'b0; lc_wa = '0; lc_wd = '0; lc_ra = '0;
      cn_we = 1'b0; cn_wa = '0; cn_wd = '0; cn_ra = '0;
      x_we = 1'b0; x_wa = '0; x_wd = '0; x_ra = '0;
      y_we = 1'b0; y_wa = '0; y_wd = '0; y_ra = '0;
      case (state_ff)
         S_IDLE: begin
            if (start && cmd.func == FUNC_LOAD && len_eff < LW'(MAX_LEN - 1)) begin
               txt_we = 1'b1;
               txt_wa = AW'(len_eff);
               txt_wd = ch_sat;
            end
         end
         S_RD0: begin
            sa_ra = a_ff;
            rk_ra = a_ff;
            lc_ra = a_ff;
         end
         S_Q0: rk_ra = a_ff;
         S_Q1: rk_ra = b_ff;
         S_Q2: lc_ra = ((ra_ff < rk_rd) ? ra_ff : rk_rd) + AW'(1);
         S_Q3: lc_ra = r_ff + AW'(1);
         S_I0: txt_ra = AW'(i_ff);
         S_I1: begin
            x_we = 1'b1;
            x_wa = AW'(i_ff);
            x_wd = (LW'(i_ff) < len_ff) ? (KW'(txt_rd) + KW'(1)) : '0;
            y_we = 1'b1;
            y_wa = AW'(i_ff);
            y_wd = KW'(i_ff);
         end
         S_CLR: begin
            cn_we = 1'b1;
            cn_wa = BW'(i_ff);
         end
         S_CN0: y_ra = AW'(i_ff);
         S_CN1: x_ra = AW'(y_rd);
         S_CN2: cn_ra = BW'(x_rd);
         S_CN3: begin
            cn_we = 1'b1;
            cn_wa = BW'(kv_ff);
            cn_wd = cn_rd + LW'(1);
         end
         S_PR0: cn_ra = BW'(i_ff);
         S_PR1: begin
            cn_we = 1'b1;
            cn_wa = BW'(i_ff);
            cn_wd = acc_ff + cn_rd;
         end
         S_PL0: y_ra = AW'(i_ff - CW'(1));
         S_PL1: x_ra = AW'(y_rd);
         S_PL2: cn_ra = BW'(x_rd);
         S_PL3: begin
            cn_we = 1'b1;
            cn_wa = BW'(kv_ff);
            cn_wd = cm1_w;
            sa_we = 1'b1;
            sa_wa = AW'(cm1_w);
            sa_wd = s_ff;
         end
         S_Y1: begin
            y_we = 1'b1;
            y_wa = AW'(p_ff);
            y_wd = KW'(i_ff);
         end
         S_Y2A: sa_ra = AW'(i_ff);
         S_Y2B: begin
            y_we = (DW'(sa_rd) >= k_ff);
            y_wa = AW'(p_ff);
            y_wd = KW'(DW'(sa_rd) - k_ff);
         end
         S_R0: sa_ra = '0;
         S_R1: begin
            x_we = 1'b1;
            x_wa = sa_rd;
         end
         S_RA: sa_ra = AW'(i_ff);
         S_RB: y_ra = sa_rd;
         S_RC: y_ra = b_ff;
         S_RD: begin
            if (ya_ff == y_rd && ak_w < DW'(n_w) && bk_w < DW'(n_w)) begin
               y_ra = AW'(ak_w);
            end else begin
               x_we = 1'b1;
               x_wa = a_ff;
               x_wd = KW'(p_ff);
            end
         end
         S_RE: y_ra = AW'(bk_w);
         S_RF: begin
            x_we = 1'b1;
            x_wa = a_ff;
            x_wd = (ya_ff == y_rd) ? KW'(p_ff - LW'(1)) : KW'(p_ff);
         end
         S_K0: sa_ra = AW'(i_ff);
         S_K1: begin
            rk_we = 1'b1;
            rk_wa = sa_rd;
            rk_wd = AW'(i_ff);
         end
         S_H0: rk_ra = AW'(i_ff);
         S_H1: begin
            if (rk_rd == '0) begin
               lc_we = 1'b1;
            end else begin
               sa_ra = rk_rd - AW'(1);
            end
         end
         S_H3: begin
            if (ih_w < DW'(n_w) && jh_w < DW'(n_w)) begin
               txt_ra = AW'(ih_w);
            end else begin
               lc_we = 1'b1;
               lc_wa = r_ff;
               lc_wd = AW'(h_ff);
            end
         end
         S_H4: txt_ra = AW'(jh_w);
         S_H5: begin
            if (ta_ff != sym_b) begin
               lc_we = 1'b1;
               lc_wa = r_ff;
               lc_wd = AW'(h_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // key arrays swap roles after every sort pass but the initial one
   always_comb begin
      if (sel_ff) begin
         k1_we = x_we; k1_wa = x_wa; k1_wd = x_wd; k1_ra = x_ra;
         k0_we = y_we; k0_wa = y_wa; k0_wd = y_wd; k0_ra = y_ra;
         x_rd = k1_rd;
         y_rd = k0_rd;
      end else begin
         k0_we = x_we; k0_wa = x_wa; k0_wd = x_wd; k0_ra = x_ra;
         k1_we = y_we; k1_wa = y_wa; k1_wd = y_wd; k1_ra = y_ra;
         x_rd = k0_rd;
         y_rd = k1_rd;
      end
   end

   sallcp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text (
      .clock(clock), .we(txt_we), .waddr(txt_wa), .wdata(txt_wd),
      .raddr(txt_ra), .rdata(txt_rd));
   sallcp_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_sa (
      .clock(clock), .we(sa_we), .waddr(sa_wa), .wdata(sa_wd),
      .raddr(sa_ra), .rdata(sa_rd));
   sallcp_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_rank (
      .clock(clock), .we(rk_we), .waddr(rk_wa), .wdata(rk_wd),
      .raddr(rk_ra), .rdata(rk_rd));
   sallcp_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_lcp (
      .clock(clock), .we(lc_we), .waddr(lc_wa), .wdata(lc_wd),
      .raddr(lc_ra), .rdata(lc_rd));
   sallcp_ram #(.WIDTH(KW), .DEPTH(MAX_LEN)) u_key0 (
      .clock(clock), .we(k0_we), .waddr(k0_wa), .wdata(k0_wd),
      .raddr(k0_ra), .rdata(k0_rd));
   sallcp_ram #(.WIDTH(KW), .DEPTH(MAX_LEN)) u_key1 (
      .clock(clock), .we(k1_we), .waddr(k1_wa), .wdata(k1_wd),
      .raddr(k1_ra), .rdata(k1_rd));
   sallcp_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_count (
      .clock(clock), .we(cn_we), .waddr(cn_wa), .wdata(cn_wd),
      .raddr(cn_ra), .rdata(cn_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         len_ff    <= '0;
         built_ff  <= 1'b0;
         sel_ff    <= 1'b0;
         csinit_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  res_ff <= res_start;
                  a_ff   <= AW'(cmd.index_a);
                  b_ff   <= AW'(cmd.index_b);
                  case (cmd.func)
                     FUNC_LOAD: begin
                        built_ff <= 1'b0;
                        if (len_eff < LW'(MAX_LEN - 1)) begin
                           len_ff <= len_eff + LW'(1);
                        end else begin
                           len_ff <= len_eff;
                        end
                        if (cmd.last) begin
                           i_ff     <= '0;
                           sel_ff   <= 1'b0;
                           state_ff <= S_I0;
                        end else begin
                           state_ff <= S_FIN;
                        end
                     end
                     FUNC_READ: begin
                        if (!built_ff || ia_x > len_x) begin
                           state_ff <= S_FIN;
                        end else begin
                           state_ff <= S_RD0;
                        end
                     end
                     FUNC_LCP: begin
                        if (!built_ff || ia_x > len_x || ib_x > len_x || ia_x == ib_x) begin
                           state_ff <= S_FIN;
                        end else begin
                           state_ff <= S_Q0;
                        end
                     end
                     default: begin
                        state_ff <= S_FIN;
                     end
                  endcase
               end
            end
            S_FIN: state_ff <= S_IDLE;
            S_RD0: state_ff <= S_RD1;
            S_RD1: begin
               res_ff.suffix_start <= 10'(sa_rd);
               res_ff.suffix_rank  <= 10'(rk_rd);
               res_ff.lcp_value    <= 10'(lc_rd);
               state_ff            <= S_FIN;
            end
            S_Q0: state_ff <= S_Q1;
            S_Q1: begin
               ra_ff    <= rk_rd;
               state_ff <= S_Q2;
            end
            S_Q2: begin
               r_ff     <= ((ra_ff < rk_rd) ? ra_ff : rk_rd) + AW'(1);
               hi_ff    <= (ra_ff < rk_rd) ? rk_rd : ra_ff;
               mn_ff    <= '1;
               state_ff <= S_Q3;
            end
            S_Q3: begin
               mn_ff <= mn_new;
               if (r_ff == hi_ff) begin
                  res_ff.lcp_value <= 10'(mn_new);
                  state_ff         <= S_FIN;
               end else begin
                  r_ff <= r_ff + AW'(1);
               end
            end
            // initial keys
            S_I0: state_ff <= S_I1;
            S_I1: begin
               if (LW'(i_ff) == n_w - LW'(1)) begin
                  i_ff      <= '0;
                  m_ff      <= CW'(ALPHABET + 1);
                  csinit_ff <= 1'b1;
                  state_ff  <= S_CLR;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_I0;
               end
            end
            // counting sort
            S_CLR: begin
               if (i_ff == m_ff - CW'(1)) begin
                  i_ff     <= '0;
                  state_ff <= S_CN0;
               end else begin
                  i_ff <= i_ff + CW'(1);
               end
            end
            S_CN0: state_ff <= S_CN1;
            S_CN1: state_ff <= S_CN2;
            S_CN2: begin
               kv_ff    <= x_rd;
               state_ff <= S_CN3;
            end
            S_CN3: begin
               if (LW'(i_ff) == n_w - LW'(1)) begin
                  i_ff     <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_PR0;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_CN0;
               end
            end
            S_PR0: state_ff <= S_PR1;
            S_PR1: begin
               acc_ff <= acc_ff + cn_rd;
               if (i_ff == m_ff - CW'(1)) begin
                  i_ff     <= CW'(n_w);
                  state_ff <= S_PL0;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_PR0;
               end
            end
            S_PL0: state_ff <= S_PL1;
            S_PL1: begin
               s_ff     <= AW'(y_rd);
               state_ff <= S_PL2;
            end
            S_PL2: begin
               kv_ff    <= x_rd;
               state_ff <= S_PL3;
            end
            S_PL3: begin
               if (i_ff == CW'(1)) begin
                  if (csinit_ff) begin
                     csinit_ff <= 1'b0;
                     k_ff      <= DW'(1);
                     p_ff      <= '0;
                     i_ff      <= CW'(n_w - LW'(1));
                     state_ff  <= S_Y1;
                  end else begin
                     sel_ff   <= ~sel_ff;
                     state_ff <= S_R0;
                  end
               end else begin
                  i_ff     <= i_ff - CW'(1);
                  state_ff <= S_PL0;
               end
            end
            // second key order
            S_Y1: begin
               p_ff <= p_ff + LW'(1);
               if (LW'(i_ff) == n_w - LW'(1)) begin
                  i_ff     <= '0;
                  state_ff <= S_Y2A;
               end else begin
                  i_ff <= i_ff + CW'(1);
               end
            end
            S_Y2A: state_ff <= S_Y2B;
            S_Y2B: begin
               if (DW'(sa_rd) >= k_ff) begin
                  p_ff <= p_ff + LW'(1);
               end
               if (LW'(i_ff) == n_w - LW'(1)) begin
                  i_ff     <= '0;
                  state_ff <= S_CLR;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_Y2A;
               end
            end
            // renumber keys
            S_R0: state_ff <= S_R1;
            S_R1: begin
               b_ff     <= sa_rd;
               p_ff     <= LW'(1);
               i_ff     <= CW'(1);
               state_ff <= S_RA;
            end
            S_RA: state_ff <= S_RB;
            S_RB: begin
               a_ff     <= sa_rd;
               state_ff <= S_RC;
            end
            S_RC: begin
               ya_ff    <= y_rd;
               state_ff <= S_RD;
            end
            S_RD: begin
               if (ya_ff == y_rd && ak_w < DW'(n_w) && bk_w < DW'(n_w)) begin
                  state_ff <= S_RE;
               end else begin
                  p_ff <= p_ff + LW'(1);
                  b_ff <= a_ff;
                  if (LW'(i_ff) == n_w - LW'(1)) begin
                     state_ff <= S_DEND;
                  end else begin
                     i_ff     <= i_ff + CW'(1);
                     state_ff <= S_RA;
                  end
               end
            end
            S_RE: begin
               ya_ff    <= y_rd;
               state_ff <= S_RF;
            end
            S_RF: begin
               if (ya_ff != y_rd) begin
                  p_ff <= p_ff + LW'(1);
               end
               b_ff <= a_ff;
               if (LW'(i_ff) == n_w - LW'(1)) begin
                  state_ff <= S_DEND;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_RA;
               end
            end
            S_DEND: begin
               if (p_ff >= n_w || (k_ff << 1) >= DW'(n_w)) begin
                  i_ff     <= '0;
                  state_ff <= S_K0;
               end else begin
                  m_ff     <= CW'(p_ff);
                  k_ff     <= k_ff << 1;
                  p_ff     <= '0;
                  i_ff     <= CW'(DW'(n_w) - (k_ff << 1));
                  state_ff <= S_Y1;
               end
            end
            // rank
            S_K0: state_ff <= S_K1;
            S_K1: begin
               if (LW'(i_ff) == n_w - LW'(1)) begin
                  i_ff     <= '0;
                  h_ff     <= '0;
                  state_ff <= S_H0;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_K0;
               end
            end
            // height by kasai
            S_H0: state_ff <= S_H1;
            S_H1: begin
               r_ff <= rk_rd;
               if (rk_rd == '0) begin
                  h_ff <= '0;
                  if (LW'(i_ff) == n_w - LW'(1)) begin
                     built_ff <= 1'b1;
                     state_ff <= S_FIN;
                  end else begin
                     i_ff     <= i_ff + CW'(1);
                     state_ff <= S_H0;
                  end
               end else begin
                  h_ff     <= LW'(hd_w);
                  state_ff <= S_H2;
               end
            end
            S_H2: begin
               j_ff     <= sa_rd;
               state_ff <= S_H3;
            end
            S_H3: begin
               if (ih_w < DW'(n_w) && jh_w < DW'(n_w)) begin
                  state_ff <= S_H4;
               end else if (LW'(i_ff) == n_w - LW'(1)) begin
                  built_ff <= 1'b1;
                  state_ff <= S_FIN;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_H0;
               end
            end
            S_H4: begin
               ta_ff    <= (ih_w < DW'(len_ff)) ? (9'(txt_rd) + 9'd1) : 9'd0;
               state_ff <= S_H5;
            end
            S_H5: begin
               if (ta_ff == sym_b) begin
                  h_ff     <= h_ff + LW'(1);
                  state_ff <= S_H3;
               end else if (LW'(i_ff) == n_w - LW'(1)) begin
                  built_ff <= 1'b1;
                  state_ff <= S_FIN;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_H0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_FIN);
   assign res  = res_ff;

endmodule

>>> sv/suffix_array_lcp_builder_core.sv
`timescale 1ns / 1ps
// responses are registered from the sequencer finish state; an lcp query
// scans the lcp array over the rank distance; a new request is accepted only
// when the sequencer is idle and no response is left waiting to be taken
// a final load also builds: initial sort, doubling rounds, rank, then kasai
// one transaction in flight at a time, all steps run on the one sequencer
// reset: synchronous, clears text length and built flag, memories uncleared
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder_core
// suffix array and lcp builder with request and response channels
// ----------------------------------------------------------------------------
module suffix_array_lcp_builder_core #(
   parameter int MAX_LEN  = sallcp_pkg::MAX_LEN_DEF,
   parameter int ALPHABET = sallcp_pkg::ALPHABET_DEF
) (
   input logic          clock,
   input logic          reset,
   sallcp_req_if.sink   req_ch,
   sallcp_rsp_if.source rsp_ch
);
   import sallcp_pkg::*;

   logic    start;
   logic    busy;
   logic    done;
   cmd_type cmd;
   res_type res;
   logic    rsp_valid_ff;
   res_type rsp_ff;

   assign req_ch.ready = !busy && (!rsp_valid_ff || rsp_ch.ready);
   assign start        = req_ch.valid && req_ch.ready;
   assign cmd          = '{func: req_ch.func, ch: req_ch.ch, last: req_ch.last,
                           index_a: req_ch.index_a, index_b: req_ch.index_b};

   sallcp_seq #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_seq (
      .clock(clock), .reset(reset), .start(start), .cmd(cmd),
      .busy(busy), .done(done), .res(res));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done) begin
         rsp_ff <= res;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_ff.status;
   assign rsp_ch.suffix_start = rsp_ff.suffix_start;
   assign rsp_ch.suffix_rank  = rsp_ff.suffix_rank;
   assign rsp_ch.lcp_value    = rsp_ff.lcp_value;

endmodule
